FILE: src/saac_pkg.sv
// Shared types and constants for the swept box clip block.
package saac_pkg;

  localparam int CNT_W   = 7;   // box_count register width
  localparam int IDX_W   = 6;   // box_index field width
  localparam int COORD_W = 32;
  localparam int SPD_W   = 16;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CLIP  = 1'b1;
  localparam logic AXIS_X   = 1'b0;
  localparam logic AXIS_Z   = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [SPD_W-1:0]   speed_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } box_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] index;
    box_t             box;
  } box_wr_t;

  // Query token that walks the cell row.
  typedef struct packed {
    logic   valid;
    logic   axis;
    coord_t lo_x;
    coord_t lo_y;
    coord_t lo_z;
    coord_t hi_x;
    coord_t hi_y;
    coord_t hi_z;
    speed_t speed;
  } tok_t;

endpackage

FILE: src/saac_req_if.sv
// Request channel: box writes and clip queries.
interface saac_req_if;
  import saac_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [IDX_W-1:0]          box_index;
  logic                      axis;
  logic signed [COORD_W-1:0] coord_a_x;
  logic signed [COORD_W-1:0] coord_a_y;
  logic signed [COORD_W-1:0] coord_a_z;
  logic signed [COORD_W-1:0] coord_b_x;
  logic signed [COORD_W-1:0] coord_b_y;
  logic signed [COORD_W-1:0] coord_b_z;
  logic signed [SPD_W-1:0]   move_speed;

  modport source (
    output valid, opcode, box_index, axis, coord_a_x, coord_a_y, coord_a_z,
    output coord_b_x, coord_b_y, coord_b_z, move_speed,
    input  ready
  );
  modport sink (
    input  valid, opcode, box_index, axis, coord_a_x, coord_a_y, coord_a_z,
    input  coord_b_x, coord_b_y, coord_b_z, move_speed,
    output ready
  );
endinterface

FILE: src/saac_rsp_if.sv
// Response channel: clipped speed.
interface saac_rsp_if;
  import saac_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [SPD_W-1:0] clipped_speed;

  modport source (output valid, clipped_speed, input ready);
  modport sink (input valid, clipped_speed, output ready);
endinterface

FILE: src/saac_cell.sv
// One table entry: holds a box and clips a passing query token against it.
module saac_cell import saac_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic [CNT_W-1:0] box_count,
  input  box_wr_t          wr,
  input  tok_t             tok_in,
  output tok_t             tok_out
);

  localparam bit               IN_TAB = (IDX < (1 << IDX_W));
  localparam bit               IN_CNT = (IDX < (1 << CNT_W));
  localparam logic [IDX_W-1:0] IDX_T  = IDX_W'(IDX);
  localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);

  box_t   box;
  tok_t   tok;
  logic   active;
  logic   ov_x, ov_y, ov_z, ov;
  coord_t lo_a, hi_a, bmin_a, bmax_a;
  coord_t gap_pos, gap_neg;
  coord_t spd32, spd1_32;
  speed_t spd1, spd2;

  always_ff @(posedge clk) begin
    if (IN_TAB && wr.en && wr.index == IDX_T) begin
      box <= wr.box;
    end
  end

  always_comb begin
    active = IN_CNT && (box_count > IDX_C);
    ov_x = (tok_in.lo_x < box.max_x) && (tok_in.hi_x > box.min_x);
    ov_y = (tok_in.lo_y < box.max_y) && (tok_in.hi_y > box.min_y);
    ov_z = (tok_in.lo_z < box.max_z) && (tok_in.hi_z > box.min_z);
    ov   = active && ov_y && ((tok_in.axis == AXIS_Z) ? ov_x : ov_z);

    lo_a   = (tok_in.axis == AXIS_Z) ? tok_in.lo_z : tok_in.lo_x;
    hi_a   = (tok_in.axis == AXIS_Z) ? tok_in.hi_z : tok_in.hi_x;
    bmin_a = (tok_in.axis == AXIS_Z) ? box.min_z : box.min_x;
    bmax_a = (tok_in.axis == AXIS_Z) ? box.max_z : box.max_x;

    gap_pos = bmin_a - hi_a;
    gap_neg = bmax_a - lo_a;

    // Forward gap first; a wrapped result may flip the sign for the back check.
    spd32 = COORD_W'(tok_in.speed);
    spd1  = tok_in.speed;
    if (ov && tok_in.speed > 0 && hi_a <= bmin_a && gap_pos < spd32) begin
      spd1 = gap_pos[SPD_W-1:0];
    end
    spd1_32 = COORD_W'(spd1);
    spd2    = spd1;
    if (ov && spd1 < 0 && lo_a >= bmax_a && gap_neg > spd1_32) begin
      spd2 = gap_neg[SPD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
    end else if (adv) begin
      tok.valid <= tok_in.valid;
    end
    if (adv) begin
      tok.axis  <= tok_in.axis;
      tok.lo_x  <= tok_in.lo_x;
      tok.lo_y  <= tok_in.lo_y;
      tok.lo_z  <= tok_in.lo_z;
      tok.hi_x  <= tok_in.hi_x;
      tok.hi_y  <= tok_in.hi_y;
      tok.hi_z  <= tok_in.hi_z;
      tok.speed <= spd2;
    end
  end

  assign tok_out = tok;

endmodule

FILE: src/swept_aabb_axis_clip.sv
// Top level: entry stage, row of box cells, output register.
//
//  channel  | dir | handshake        | payload
//  req      | in  | valid / ready    | opcode, box_index, axis, coord_a_*, coord_b_*, move_speed
//  rsp      | out | valid / ready    | clipped_speed
//  cfg      | in  | cfg_we           | cfg_wdata (box_count)
//
// Every beat, write or query, walks the row of MAX_BOXES cells one cell per cycle while the row is not held,
// and ready returns once its token is taken into the output register.
// A box write lands in its cell at the accept edge; its token returns zero.
// One item is in flight at a time; the result waits in the output register
// and the row holds while a tail token waits and that register is full and not taken.
// Synchronous reset clears box_count, token and response valids and the busy flag only.
module swept_aabb_axis_clip import saac_pkg::*; #(
  parameter int MAX_BOXES = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  saac_req_if.sink         req,
  saac_rsp_if.source       rsp
);

  logic [CNT_W-1:0] box_count;
  logic             busy;
  logic             accept;
  logic             adv;
  logic             rsp_valid;
  speed_t           rsp_speed;
  box_wr_t          wr;
  tok_t             entry;
  tok_t             chain [MAX_BOXES+1];
  coord_t           half_x, half_z, ext_y;

  assign req.ready = !busy;
  assign accept    = req.valid && req.ready;
  // Hold the row while the tail token cannot move out.
  assign adv = !(chain[MAX_BOXES].valid && rsp_valid && !rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      box_count <= '0;
    end else if (cfg_we) begin
      box_count <= cfg_wdata;
    end
  end

  always_comb begin
    wr.en        = accept && (req.opcode == OP_WRITE);
    wr.index     = req.box_index;
    wr.box.min_x = req.coord_a_x;
    wr.box.min_y = req.coord_a_y;
    wr.box.min_z = req.coord_a_z;
    wr.box.max_x = req.coord_b_x;
    wr.box.max_y = req.coord_b_y;
    wr.box.max_z = req.coord_b_z;

    half_x = {{(COORD_W-SPD_W+1){req.coord_b_x[SPD_W-1]}}, req.coord_b_x[SPD_W-1:1]};
    half_z = {{(COORD_W-SPD_W+1){req.coord_b_z[SPD_W-1]}}, req.coord_b_z[SPD_W-1:1]};
    ext_y  = {{(COORD_W-SPD_W){req.coord_b_y[SPD_W-1]}}, req.coord_b_y[SPD_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (accept) begin
      entry.valid <= 1'b1;
    end else if (adv) begin
      entry.valid <= 1'b0;
    end
    if (accept) begin
      entry.axis <= req.axis;
      entry.lo_x <= req.coord_a_x - half_x;
      entry.hi_x <= req.coord_a_x + half_x;
      entry.lo_y <= req.coord_a_y;
      entry.hi_y <= req.coord_a_y + ext_y;
      entry.lo_z <= req.coord_a_z - half_z;
      entry.hi_z <= req.coord_a_z + half_z;
      entry.speed <= (req.opcode == OP_CLIP) ? req.move_speed : '0;
    end
  end

  assign chain[0] = entry;

  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    saac_cell #(.IDX(i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .box_count (box_count),
      .wr        (wr),
      .tok_in    (chain[i]),
      .tok_out   (chain[i+1])
    );
  end

  // Take the tail token into the output register; free the input side.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      busy      <= 1'b0;
    end else begin
      if (chain[MAX_BOXES].valid && (!rsp_valid || rsp.ready)) begin
        rsp_valid <= 1'b1;
        busy      <= 1'b0;
      end else begin
        if (rsp.ready) begin
          rsp_valid <= 1'b0;
        end
        if (accept) begin
          busy <= 1'b1;
        end
      end
    end
    if (chain[MAX_BOXES].valid && (!rsp_valid || rsp.ready)) begin
      rsp_speed <= chain[MAX_BOXES].speed;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.clipped_speed = rsp_speed;

endmodule
